FILE: rtl/core/ghsp_pkg.sv
// ----------------------------------------------------------------------------
// ghsp_pkg
// Shared types and constants of the geometric history sum predictor:
// counter format, configuration register codes and reset values, bank command.
// ----------------------------------------------------------------------------
package ghsp_pkg;

  localparam int unsigned CntW    = 5;
  localparam int unsigned ThrW    = 7;
  localparam int unsigned LenW    = 5;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned SumOutW = 8;

  typedef logic signed [CntW-1:0] cnt_t;

  localparam cnt_t CntMax = 5'sd15;
  localparam cnt_t CntMin = -5'sd15;

  typedef enum logic [CfgIdxW-1:0] {
    CfgThreshold  = 3'd0,
    CfgHistOne    = 3'd1,
    CfgHistTwo    = 3'd2,
    CfgHistThree  = 3'd3,
    CfgHistFour   = 3'd4
  } cfg_idx_e;

  localparam logic [ThrW-1:0] ThrRst = 7'd5;
  localparam logic [LenW-1:0] HistLenRst [1:4] = '{5'd2, 5'd4, 5'd8, 5'd16};

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic up;
    logic clr;
  } bank_cmd_t;

endpackage

FILE: rtl/core/ghsp_bank.sv
// ----------------------------------------------------------------------------
// ghsp_bank
// One counter table: synchronous memory with registered read, saturating
// write-back of the counter last read, and a clear write for the reset sweep.
// ----------------------------------------------------------------------------
module ghsp_bank #(
  parameter int unsigned Entries = 4096
) (
  input  logic                       clk_i,
  input  ghsp_pkg::bank_cmd_t        cmd_i,
  input  logic [$clog2(Entries)-1:0] idx_i,
  output ghsp_pkg::cnt_t             cnt_o
);

  localparam int unsigned IdxW = $clog2(Entries);

  ghsp_pkg::cnt_t    mem_q [Entries];
  ghsp_pkg::cnt_t    rd_q;
  logic [IdxW-1:0]   idx_q;
  ghsp_pkg::cnt_t    sat_d;

  always_comb begin
    if (cmd_i.up) begin
      sat_d = (rd_q < ghsp_pkg::CntMax) ? rd_q + ghsp_pkg::cnt_t'(1) : rd_q;
    end else begin
      sat_d = (rd_q > ghsp_pkg::CntMin) ? rd_q - ghsp_pkg::cnt_t'(1) : rd_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.clr) begin
      mem_q[idx_i] <= '0;
    end else if (cmd_i.wr_en) begin
      mem_q[idx_q] <= sat_d;
    end
    if (cmd_i.rd_en) begin
      rd_q  <= mem_q[idx_i];
      idx_q <= idx_i;
    end
  end

  assign cnt_o = rd_q;

endmodule

FILE: rtl/core/geometric_history_sum_predictor.sv
// ----------------------------------------------------------------------------
// geometric_history_sum_predictor
// Sums signed counters read from banked tables indexed by address and folded
// global history; predicts taken on a non-negative sum and trains on update.
//
//   channel | signals                                         | dir
//   --------+-------------------------------------------------+-----
//   in      | in_valid_i/in_ready_o, mode, pc_low,            | in
//           | resolved_taken, predicted_taken                 |
//   out     | out_valid_o/out_ready_i, taken, sum_value       | out
//   cfg     | cfg_valid_i/cfg_ready_o, cfg_index, cfg_data    | in
//
// Each request first reads all banks in parallel, then sums or writes back
// through the single write port of each bank.
// After reset a sweep clears every bank entry, during which no request is
// taken; configuration writes are taken at any time.
// A waiting result holds the sum/write-back step; one more request may be taken.
// ----------------------------------------------------------------------------
module geometric_history_sum_predictor #(
  parameter int unsigned TABLE_COUNT   = 5,
  parameter int unsigned TABLE_ENTRIES = 4096,
  parameter int unsigned GHIST_W       = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic                                mode_i,
  input  logic [11:0]                         pc_low_i,
  input  logic                                resolved_taken_i,
  input  logic                                predicted_taken_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                taken_o,
  output logic signed [ghsp_pkg::SumOutW-1:0] sum_value_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [ghsp_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [ghsp_pkg::ThrW-1:0]           cfg_data_i
);

  localparam int unsigned IdxW   = $clog2(TABLE_ENTRIES);
  localparam int unsigned BaseW  = (IdxW < 12) ? IdxW : 12;
  localparam int unsigned XorW   = (IdxW > GHIST_W) ? IdxW : GHIST_W;
  localparam int unsigned NChunk = (XorW + IdxW - 1) / IdxW;
  localparam int unsigned SumW   = $clog2(TABLE_COUNT * 16) + 1;

  typedef enum logic [1:0] {
    StClear,
    StIdle,
    StExec
  } state_e;

  function automatic logic [IdxW-1:0] fold_mod(input logic [XorW-1:0] x);
    logic [NChunk*IdxW-1:0] xp;
    logic [IdxW+1:0]        acc;
    logic [IdxW:0]          f1;
    logic [IdxW-1:0]        f2;
    xp  = (NChunk*IdxW)'(x);
    acc = '0;
    for (int c = 0; c < NChunk; c++) begin
      acc = acc + (IdxW+2)'(xp[c*IdxW +: IdxW]);
    end
    f1 = (IdxW+1)'(acc[IdxW-1:0]) + (IdxW+1)'(acc[IdxW+1:IdxW]);
    f2 = f1[IdxW-1:0] + IdxW'(f1[IdxW]);
    if (f2 == {IdxW{1'b1}}) begin
      f2 = '0;
    end
    return f2;
  endfunction

  state_e                           state_q;
  logic [IdxW-1:0]                  clr_idx_q;
  logic [GHIST_W-1:0]               hist_q;
  logic signed [SumW-1:0]           kept_q;
  logic [ghsp_pkg::ThrW-1:0]        thr_q;
  logic [ghsp_pkg::LenW-1:0]        hlen_q [1:4];
  logic                             mode_q;
  logic                             res_q;
  logic                             pred_q;
  logic                             out_valid_q;
  logic                             taken_q;
  logic signed [ghsp_pkg::SumOutW-1:0] sum_out_q;

  logic                             in_acc;
  logic                             exec_go;
  logic                             train;
  logic [SumW-1:0]                  mag;
  logic signed [SumW-1:0]           sum_d;
  logic signed [SumW-1:0]           kept_d;
  ghsp_pkg::bank_cmd_t              cmd;
  logic [IdxW-1:0]                  idx [TABLE_COUNT];
  logic [IdxW-1:0]                  bank_idx [TABLE_COUNT];
  ghsp_pkg::cnt_t                   cnt [TABLE_COUNT];

  assign in_ready_o  = (state_q == StIdle);
  assign cfg_ready_o = 1'b1;
  assign in_acc      = in_valid_i && in_ready_o;
  assign exec_go     = (state_q == StExec) && (!out_valid_q || out_ready_i);

  for (genvar t = 0; t < TABLE_COUNT; t++) begin : g_bank
    if (t == 0) begin : g_base
      assign idx[t] = IdxW'(pc_low_i[BaseW-1:0]);
    end else begin : g_hist
      localparam int unsigned L = (t < 5) ? t : 4;
      logic [GHIST_W-1:0] mask;
      always_comb begin
        for (int b = 0; b < GHIST_W; b++) begin
          mask[b] = (32'(b) < 32'(hlen_q[L]));
        end
      end
      assign idx[t] = fold_mod(XorW'(pc_low_i[BaseW-1:0]) ^ XorW'(hist_q & mask));
    end
    assign bank_idx[t] = (state_q == StClear) ? clr_idx_q : idx[t];
    ghsp_bank #(
      .Entries(TABLE_ENTRIES)
    ) u_bank (
      .clk_i(clk_i),
      .cmd_i(cmd),
      .idx_i(bank_idx[t]),
      .cnt_o(cnt[t])
    );
  end

  always_comb begin
    sum_d = SumW'(TABLE_COUNT / 2);
    for (int t = 0; t < TABLE_COUNT; t++) begin
      sum_d = sum_d + SumW'(cnt[t]);
    end
  end

  assign mag    = kept_q[SumW-1] ? SumW'(-kept_q) : SumW'(kept_q);
  assign train  = (32'(mag) <= 32'(thr_q)) || (res_q != pred_q);
  assign kept_d = mode_q ? kept_q : sum_d;

  always_comb begin
    cmd       = '0;
    cmd.rd_en = in_acc;
    cmd.clr   = (state_q == StClear);
    cmd.wr_en = exec_go && mode_q && train;
    cmd.up    = res_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= ghsp_pkg::ThrRst;
      hlen_q <= ghsp_pkg::HistLenRst;
    end else if (cfg_valid_i) begin
      unique case (ghsp_pkg::cfg_idx_e'(cfg_index_i))
        ghsp_pkg::CfgThreshold: thr_q     <= cfg_data_i;
        ghsp_pkg::CfgHistOne:   hlen_q[1] <= cfg_data_i[ghsp_pkg::LenW-1:0];
        ghsp_pkg::CfgHistTwo:   hlen_q[2] <= cfg_data_i[ghsp_pkg::LenW-1:0];
        ghsp_pkg::CfgHistThree: hlen_q[3] <= cfg_data_i[ghsp_pkg::LenW-1:0];
        ghsp_pkg::CfgHistFour:  hlen_q[4] <= cfg_data_i[ghsp_pkg::LenW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_idx_q   <= '0;
      hist_q      <= '0;
      kept_q      <= '0;
      mode_q      <= 1'b0;
      res_q       <= 1'b0;
      pred_q      <= 1'b0;
      out_valid_q <= 1'b0;
      taken_q     <= 1'b0;
      sum_out_q   <= '0;
    end else begin
      if (exec_go) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        StClear: begin
          clr_idx_q <= clr_idx_q + IdxW'(1);
          if (clr_idx_q == {IdxW{1'b1}}) begin
            state_q <= StIdle;
          end
        end
        StIdle: begin
          if (in_acc) begin
            mode_q  <= mode_i;
            res_q   <= resolved_taken_i;
            pred_q  <= predicted_taken_i;
            state_q <= StExec;
          end
        end
        StExec: begin
          if (exec_go) begin
            kept_q      <= kept_d;
            taken_q     <= !kept_d[SumW-1];
            sum_out_q   <= ghsp_pkg::SumOutW'(32'(kept_d));
            if (mode_q) begin
              hist_q <= {hist_q[GHIST_W-2:0], res_q};
            end
            state_q <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign taken_o     = taken_q;
  assign sum_value_o = sum_out_q;

endmodule
